// ----- src/smu_pkg.sv -----
// ============================================================================
// smu_pkg: shared definitions for the small matrix unit
// Field widths, operation codes and controller states used by the core and
// its channel interfaces.
// ============================================================================
`default_nettype none

package smu_pkg;

    // Fixed widths of the channel fields.
    localparam int OPCODE_W = 3;
    localparam int IDX_W    = 2;
    localparam int VALUE_W  = 16;
    localparam int RESULT_W = 34;

    // Operation codes carried by a command beat.
    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE_A = 3'd0,
        OP_WRITE_B = 3'd1,
        OP_ADD     = 3'd2,
        OP_MUL     = 3'd3,
        OP_DIAG    = 3'd4,
        OP_SWAP    = 3'd5
    } opcode_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_WR_A,
        ST_WR_B,
        ST_SWAP_RD,
        ST_SWAP_WR1,
        ST_SWAP_WR2
    } state_t;

endpackage

`default_nettype wire

// ----- src/smu_if.sv -----
// ============================================================================
// smu_if: channel interfaces of the small matrix unit
// A command channel into the unit and a result channel out of it, both with
// a valid/ready handshake.
// ============================================================================
`default_nettype none

interface smu_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [smu_pkg::OPCODE_W-1:0]         opcode;
    logic [smu_pkg::IDX_W-1:0]            row;
    logic [smu_pkg::IDX_W-1:0]            col;
    logic [smu_pkg::IDX_W-1:0]            second_row;
    logic signed [smu_pkg::VALUE_W-1:0]   value;

    modport source (output valid, output opcode, output row, output col,
                    output second_row, output value, input ready);
    modport sink   (input valid, input opcode, input row, input col,
                    input second_row, input value, output ready);
endinterface

interface smu_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [smu_pkg::RESULT_W-1:0]  result_value;
    logic [smu_pkg::IDX_W-1:0]            result_row;
    logic [smu_pkg::IDX_W-1:0]            result_col;
    logic                                 last;

    modport source (output valid, output result_value, output result_row,
                    output result_col, output last, input ready);
    modport sink   (input valid, input result_value, input result_row,
                    input result_col, input last, output ready);
endinterface

`default_nettype wire

// ----- src/smu_ram.sv -----
// ============================================================================
// smu_ram: generic single-clock RAM
// One write port and one read port with a registered read that holds its
// data while the read enable is low.
// ============================================================================
`default_nettype none

module smu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/small_matrix_unit_core.sv -----
// ============================================================================
// small_matrix_unit_core: two-matrix arithmetic unit
// Holds signed matrices A and B, swaps rows of A, and computes A+B, A*B (one
// result beat per element, in row-major order) and the sum of both diagonals of A.
// ============================================================================
// Usage.
// The command channel (cmd) carries one operation per beat: write an element
// of A or B, add, multiply, sum of both diagonals of A, or swap two rows of A. The
// result channel (res) returns DIM*DIM beats for add and multiply, the final
// one marked last, and a single last beat for the diagonal sum. Writes and
// swaps return nothing.
// A is stored row by row and B column by column, each in a RAM of DIM words
// of DIM elements, so one read of each gives a whole row of A and a whole
// column of B. A multiply therefore forms one dot product of DIM terms per
// cycle with DIM multipliers while the receiver does not stall the output.
// An add or multiply reads a row of A and a column of B for each element, a
// diagonal sum reads each row of A once, an element write reads, merges and
// writes back the word, and a row swap reads both rows and writes each into
// the other's place. The first result of a run reaches the output register
// through stage 1 and stage 2.
// A new command is taken once the internal read and arithmetic stages are
// empty, even while a finished result still waits in the output register.
// When the receiver stalls, the whole read pipeline holds, including the RAM
// read data, and resumes without loss. Reset clears the controller and all
// valid flags; the matrix contents are undefined until written.
// ============================================================================
`default_nettype none

module small_matrix_unit_core #(
    parameter int DIM       = 4,
    parameter int ELEM_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    smu_cmd_if.sink    cmd,
    smu_res_if.source  res
);

    localparam int AW    = $clog2(DIM);
    localparam int WORD  = DIM * ELEM_BITS;
    localparam int PW    = 2 * ELEM_BITS;
    // Accumulation width: wide enough for every exact sum and never below
    // the result width, so the result is always its low bits.
    localparam int ACC_W = (PW + 4 > smu_pkg::RESULT_W) ? PW + 4 : smu_pkg::RESULT_W;
    localparam logic [AW-1:0] MAX_IDX = AW'(DIM - 1);

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    logic            rd_en_a, rd_en_b, wr_en_a, wr_en_b;
    logic [AW-1:0]   rd_addr_a, rd_addr_b, wr_addr_a, wr_addr_b;
    logic [WORD-1:0] wr_data_a, wr_data_b, rd_a, rd_b;

    smu_ram #(.WIDTH(WORD), .DEPTH(DIM)) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_en_a),
        .wr_addr (wr_addr_a),
        .wr_data (wr_data_a),
        .rd_en   (rd_en_a),
        .rd_addr (rd_addr_a),
        .rd_data (rd_a)
    );

    smu_ram #(.WIDTH(WORD), .DEPTH(DIM)) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_en_b),
        .wr_addr (wr_addr_b),
        .wr_data (wr_data_b),
        .rd_en   (rd_en_b),
        .rd_addr (rd_addr_b),
        .rd_data (rd_b)
    );

    // ------------------------------------------------------------------
    // Controller and command registers
    // ------------------------------------------------------------------
    smu_pkg::state_t  state_reg, state_next;
    smu_pkg::opcode_t kind_reg, kind_next;
    logic [AW-1:0]    i_reg, i_next, j_reg, j_next;
    logic [AW-1:0]    row_reg, col_reg, r2_reg;
    logic signed [ELEM_BITS-1:0] value_reg;
    logic [WORD-1:0]  hold_reg, hold_next;

    logic cmd_ready, cmd_fire, issue, stall;
    logic row_ok, col_ok, r2_ok;
    logic [WORD-1:0] word_a, word_b;

    // The output register is the only place a stall starts: a run and the read
    // and arithmetic stages freeze while a result waits and the receiver is not ready.
    logic out_valid_reg;
    assign stall = out_valid_reg && !res.ready;

    assign row_ok   = 4'(cmd.row) < 4'(DIM);
    assign col_ok   = 4'(cmd.col) < 4'(DIM);
    assign r2_ok    = 4'(cmd.second_row) < 4'(DIM);
    assign cmd_fire = cmd.valid && cmd_ready;
    assign cmd.ready = cmd_ready;

    logic s1_valid_reg, s2_valid_reg;

    // Commands are taken only in idle with the read and arithmetic stages empty.
    assign cmd_ready = (state_reg == smu_pkg::ST_IDLE) && !s1_valid_reg && !s2_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        hold_next  = hold_reg;
        issue      = 1'b0;
        rd_en_a    = 1'b0;
        rd_en_b    = 1'b0;
        rd_addr_a  = i_reg;
        rd_addr_b  = j_reg;
        wr_en_a    = 1'b0;
        wr_en_b    = 1'b0;
        wr_addr_a  = row_reg;
        wr_addr_b  = col_reg;
        word_a     = rd_a;
        word_b     = rd_b;
        wr_data_a  = rd_a;
        wr_data_b  = rd_b;

        unique case (state_reg)
            smu_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    kind_next = smu_pkg::opcode_t'(cmd.opcode);
                    unique case (smu_pkg::opcode_t'(cmd.opcode))
                        smu_pkg::OP_WRITE_A:
                        begin
                            if (row_ok && col_ok)
                            begin
                                rd_en_a    = 1'b1;
                                rd_addr_a  = AW'(cmd.row);
                                state_next = smu_pkg::ST_WR_A;
                            end
                        end
                        smu_pkg::OP_WRITE_B:
                        begin
                            if (row_ok && col_ok)
                            begin
                                rd_en_b    = 1'b1;
                                rd_addr_b  = AW'(cmd.col);
                                state_next = smu_pkg::ST_WR_B;
                            end
                        end
                        smu_pkg::OP_ADD, smu_pkg::OP_MUL, smu_pkg::OP_DIAG:
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            state_next = smu_pkg::ST_RUN;
                        end
                        smu_pkg::OP_SWAP:
                        begin
                            if (row_ok && r2_ok && (cmd.row != cmd.second_row))
                            begin
                                rd_en_a    = 1'b1;
                                rd_addr_a  = AW'(cmd.row);
                                state_next = smu_pkg::ST_SWAP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = smu_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            smu_pkg::ST_RUN:
            begin
                if (!stall)
                begin
                    rd_en_a = 1'b1;
                    rd_en_b = 1'b1;
                    issue   = 1'b1;
                    if (kind_reg == smu_pkg::OP_DIAG)
                    begin
                        if (i_reg == MAX_IDX)
                        begin
                            state_next = smu_pkg::ST_IDLE;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    else if (j_reg == MAX_IDX)
                    begin
                        j_next = '0;
                        if (i_reg == MAX_IDX)
                        begin
                            state_next = smu_pkg::ST_IDLE;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            smu_pkg::ST_WR_A:
            begin
                word_a[col_reg*ELEM_BITS +: ELEM_BITS] = value_reg;
                wr_en_a    = 1'b1;
                wr_addr_a  = row_reg;
                wr_data_a  = word_a;
                state_next = smu_pkg::ST_IDLE;
            end
            smu_pkg::ST_WR_B:
            begin
                // B is held by columns, so the row picks the element.
                word_b[row_reg*ELEM_BITS +: ELEM_BITS] = value_reg;
                wr_en_b    = 1'b1;
                wr_addr_b  = col_reg;
                wr_data_b  = word_b;
                state_next = smu_pkg::ST_IDLE;
            end
            smu_pkg::ST_SWAP_RD:
            begin
                hold_next  = rd_a;
                rd_en_a    = 1'b1;
                rd_addr_a  = r2_reg;
                state_next = smu_pkg::ST_SWAP_WR1;
            end
            smu_pkg::ST_SWAP_WR1:
            begin
                wr_en_a    = 1'b1;
                wr_addr_a  = row_reg;
                wr_data_a  = rd_a;
                state_next = smu_pkg::ST_SWAP_WR2;
            end
            smu_pkg::ST_SWAP_WR2:
            begin
                wr_en_a    = 1'b1;
                wr_addr_a  = r2_reg;
                wr_data_a  = hold_reg;
                state_next = smu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = smu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smu_pkg::ST_IDLE;
            kind_reg  <= smu_pkg::OP_WRITE_A;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (cmd_fire)
        begin
            row_reg   <= AW'(cmd.row);
            col_reg   <= AW'(cmd.col);
            r2_reg    <= AW'(cmd.second_row);
            value_reg <= ELEM_BITS'(cmd.value);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: RAM data is valid; form the products, element sums or diagonal pair sums.
    // ------------------------------------------------------------------
    smu_pkg::opcode_t s1_kind_reg, s2_kind_reg;
    logic [AW-1:0]    s1_i_reg, s1_j_reg, s2_i_reg, s2_j_reg;
    logic             s1_first_reg, s1_last_reg, s2_first_reg, s2_last_reg;

    logic signed [PW-1:0]        prod [DIM];
    logic signed [PW-1:0]        prod_reg [DIM];
    logic signed [ACC_W-1:0]     sum1, sum_reg;
    logic signed [ELEM_BITS-1:0] a_elem_j, a_elem_i, a_elem_m, b_elem_i;
    logic [AW-1:0]               mirror_idx;

    always_comb
    begin
        for (int k = 0; k < DIM; k++)
        begin
            prod[k] = $signed(rd_a[k*ELEM_BITS +: ELEM_BITS])
                    * $signed(rd_b[k*ELEM_BITS +: ELEM_BITS]);
        end
        mirror_idx = MAX_IDX - s1_i_reg;
        a_elem_j   = rd_a[s1_j_reg*ELEM_BITS +: ELEM_BITS];
        a_elem_i   = rd_a[s1_i_reg*ELEM_BITS +: ELEM_BITS];
        a_elem_m   = rd_a[mirror_idx*ELEM_BITS +: ELEM_BITS];
        b_elem_i   = rd_b[s1_i_reg*ELEM_BITS +: ELEM_BITS];
        if (s1_kind_reg == smu_pkg::OP_DIAG)
        begin
            // Both diagonals of row i; the centre of an odd matrix counts twice.
            sum1 = ACC_W'(a_elem_i) + ACC_W'(a_elem_m);
        end
        else
        begin
            sum1 = ACC_W'(a_elem_j) + ACC_W'(b_elem_i);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 to output: reduce the dot product, pass the element sum or close the diagonal sum.
    // ------------------------------------------------------------------
    logic signed [ACC_W-1:0] dot, diag_acc_reg, diag_total, out_sum;
    logic                    emit;
    logic signed [smu_pkg::RESULT_W-1:0] out_value_reg;
    logic [smu_pkg::IDX_W-1:0] out_row_reg, out_col_reg;
    logic                    out_last_reg;

    always_comb
    begin
        dot = '0;
        for (int k = 0; k < DIM; k++)
        begin
            dot = dot + ACC_W'(prod_reg[k]);
        end
        diag_total = (s2_first_reg ? '0 : diag_acc_reg) + sum_reg;
        if (s2_kind_reg == smu_pkg::OP_MUL)
        begin
            out_sum = dot;
        end
        else if (s2_kind_reg == smu_pkg::OP_DIAG)
        begin
            out_sum = diag_total;
        end
        else
        begin
            out_sum = sum_reg;
        end
        emit = s2_valid_reg && ((s2_kind_reg != smu_pkg::OP_DIAG) || s2_last_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            if (issue)
            begin
                s1_kind_reg  <= kind_reg;
                s1_i_reg     <= i_reg;
                s1_j_reg     <= j_reg;
                s1_first_reg <= (i_reg == '0);
                s1_last_reg  <= (i_reg == MAX_IDX)
                              && ((j_reg == MAX_IDX) || (kind_reg == smu_pkg::OP_DIAG));
            end
            s2_kind_reg  <= s1_kind_reg;
            s2_i_reg     <= s1_i_reg;
            s2_j_reg     <= s1_j_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            sum_reg      <= sum1;
            for (int k = 0; k < DIM; k++)
            begin
                prod_reg[k] <= prod[k];
            end
            if (s2_valid_reg && (s2_kind_reg == smu_pkg::OP_DIAG))
            begin
                diag_acc_reg <= diag_total;
            end
            if (emit)
            begin
                out_value_reg <= out_sum[smu_pkg::RESULT_W-1:0];
                out_last_reg  <= s2_last_reg;
                if (s2_kind_reg == smu_pkg::OP_DIAG)
                begin
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                end
                else
                begin
                    out_row_reg <= smu_pkg::IDX_W'(s2_i_reg);
                    out_col_reg <= smu_pkg::IDX_W'(s2_j_reg);
                end
            end
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.result_value = out_value_reg;
    assign res.result_row   = out_row_reg;
    assign res.result_col   = out_col_reg;
    assign res.last         = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_issue_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s1_valid_reg) |-> $past(state_reg == smu_pkg::ST_RUN))
        else $error("read stage filled outside a run");

    a_no_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en_a || wr_en_b) |-> (state_reg != smu_pkg::ST_RUN))
        else $error("matrix write during a run");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> ($stable(s2_valid_reg) && $stable(s1_valid_reg)))
        else $error("pipeline moved while the output was stalled");

    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == smu_pkg::ST_SWAP_WR2) |-> ($past(state_reg) == smu_pkg::ST_SWAP_WR1))
        else $error("second swap write without the first");

endmodule

`default_nettype wire
